/* rtl/mvr_pkg.sv */
// ----------------------------------------------------------------------------
// mvr_pkg
// Shared types, register indexes and the CRC step for the v2 frame receiver.
// ----------------------------------------------------------------------------
package mvr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_EXTRA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

  // Reset values of the registers
  localparam logic [7:0] START_MARKER_RST = 8'd253;
  localparam logic [7:0] CRC_EXTRA_RST    = 8'd0;
  localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd20;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  // Result kinds
  localparam logic RES_PAYLOAD   = 1'b0;
  localparam logic RES_FRAME_END = 1'b1;

  // Live configuration seen by the parser
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] crc_extra_byte;
    logic [7:0] max_payload_length;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  payload_index;
    logic [7:0]  payload_length;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic [23:0] message_id;
    logic        crc_match;
    logic        over_length;
  } res_t;

  // One byte of the X.25 / MCRF4XX checksum
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* rtl/mvr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mvr_cfg_regs
// Configuration register file: start marker, CRC extra byte, length limit.
// ----------------------------------------------------------------------------
module mvr_cfg_regs
  import mvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  logic [7:0] start_marker_r, start_marker_nxt;
  logic [7:0] crc_extra_r, crc_extra_nxt;
  logic [7:0] max_payload_r, max_payload_nxt;

  // decode the write; unknown index is dropped
  always_comb begin
    start_marker_nxt = start_marker_r;
    crc_extra_nxt    = crc_extra_r;
    max_payload_nxt  = max_payload_r;
    if (wr_en) begin
      case (wr_index)
        REG_START_MARKER: start_marker_nxt = wr_data;
        REG_CRC_EXTRA:    crc_extra_nxt    = wr_data;
        REG_MAX_PAYLOAD:  max_payload_nxt  = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      crc_extra_r    <= CRC_EXTRA_RST;
      max_payload_r  <= MAX_PAYLOAD_RST;
    end else begin
      start_marker_r <= start_marker_nxt;
      crc_extra_r    <= crc_extra_nxt;
      max_payload_r  <= max_payload_nxt;
    end
  end

  assign cfg.start_marker       = start_marker_r;
  assign cfg.crc_extra_byte     = crc_extra_r;
  assign cfg.max_payload_length = max_payload_r;

endmodule

/* rtl/mvr_parser.sv */
// ----------------------------------------------------------------------------
// mvr_parser
// Frame state machine: hunt, header capture, payload stream, checksum check.
// ----------------------------------------------------------------------------
module mvr_parser
  import mvr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output logic       res_push,
  output res_t       res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC_LO  = 3'd3;
  localparam logic [2:0] PH_CRC_HI  = 3'd4;

  // header byte positions after the start byte
  localparam logic [7:0] HB_LEN    = 8'd1;
  localparam logic [7:0] HB_SYS    = 8'd5;
  localparam logic [7:0] HB_COMP   = 8'd6;
  localparam logic [7:0] HB_MSG0   = 8'd7;
  localparam logic [7:0] HB_MSG1   = 8'd8;
  localparam logic [7:0] HB_MSG2   = 8'd9;
  localparam logic [7:0] HB_LAST   = 8'd9;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  sys_r, sys_nxt;
  logic [7:0]  comp_r, comp_nxt;
  logic [23:0] msg_r, msg_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_byte;
  logic [8:0]  idx_plus1;

  assign crc_byte  = crc_fold(crc_r, rx_byte);
  assign idx_plus1 = {1'b0, byte_count_r} + 9'd1;

  // next state and result for one accepted byte
  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    sys_nxt          = sys_r;
    comp_nxt         = comp_r;
    msg_nxt          = msg_r;
    crc_nxt          = crc_r;
    crc_lo_nxt       = crc_lo_r;
    res_push         = 1'b0;

    res.result_kind    = RES_PAYLOAD;
    res.data_byte      = 8'h00;
    res.payload_index  = 8'h00;
    res.payload_length = frame_length_r;
    res.system_id      = sys_r;
    res.component_id   = comp_r;
    res.message_id     = msg_r;
    res.crc_match      = 1'b0;
    res.over_length    = 1'b0;

    if (byte_en) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.start_marker) begin
            crc_nxt        = crc_fold(CRC_SEED, rx_byte);
            byte_count_nxt = 8'd1;
            phase_nxt      = PH_HEADER;
          end
        end
        PH_HEADER: begin
          crc_nxt        = crc_byte;
          byte_count_nxt = byte_count_r + 8'd1;
          case (byte_count_r)
            HB_LEN:  frame_length_nxt = rx_byte;
            HB_SYS:  sys_nxt          = rx_byte;
            HB_COMP: comp_nxt         = rx_byte;
            HB_MSG0: msg_nxt          = {16'h0000, rx_byte};
            HB_MSG1: msg_nxt          = {8'h00, rx_byte, msg_r[7:0]};
            HB_MSG2: msg_nxt          = {rx_byte, msg_r[15:0]};
            default: ;
          endcase
          if (byte_count_r == HB_LAST) begin
            byte_count_nxt = 8'd0;
            if (frame_length_r == 8'd0) begin
              // empty payload: fold the extra byte now
              crc_nxt   = crc_fold(crc_byte, cfg.crc_extra_byte);
              phase_nxt = PH_CRC_LO;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_push          = 1'b1;
          res.data_byte     = rx_byte;
          res.payload_index = byte_count_r;
          crc_nxt           = crc_byte;
          byte_count_nxt    = byte_count_r + 8'd1;
          if (idx_plus1 >= {1'b0, frame_length_r}) begin
            byte_count_nxt = 8'd0;
            crc_nxt        = crc_fold(crc_byte, cfg.crc_extra_byte);
            phase_nxt      = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          res_push        = 1'b1;
          res.result_kind = RES_FRAME_END;
          res.crc_match   = ({rx_byte, crc_lo_r} == crc_r);
          res.over_length = (frame_length_r > cfg.max_payload_length);
          phase_nxt       = PH_HUNT;
          byte_count_nxt  = 8'd0;
          crc_nxt         = CRC_SEED;
        end
        default: begin
          phase_nxt      = PH_HUNT;
          byte_count_nxt = 8'd0;
          crc_nxt        = CRC_SEED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      byte_count_r   <= 8'd0;
      frame_length_r <= 8'd0;
      sys_r          <= 8'd0;
      comp_r         <= 8'd0;
      msg_r          <= 24'd0;
      crc_r          <= CRC_SEED;
      crc_lo_r       <= 8'd0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      sys_r          <= sys_nxt;
      comp_r         <= comp_nxt;
      msg_r          <= msg_nxt;
      crc_r          <= crc_nxt;
      crc_lo_r       <= crc_lo_nxt;
    end
  end

  // payload phase is only entered with a nonzero length
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (frame_length_r != 8'd0))
    else $error("payload phase with zero frame length");

  // header counter stays inside the nine header bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (byte_count_r >= HB_LEN && byte_count_r <= HB_LAST))
    else $error("header byte counter out of range");

endmodule

/* rtl/mvr_out_buf.sv */
// ----------------------------------------------------------------------------
// mvr_out_buf
// Result register with a skid stage so the input side sees a registered ready.
// ----------------------------------------------------------------------------
module mvr_out_buf
  import mvr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic slot_free;

  assign slot_free = !main_valid_r || out_ready;
  assign can_push  = !skid_valid_r;

  // main register drains first; skid catches a word while main is stalled
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (slot_free) begin
      main_valid_nxt = push;
      if (push) begin
        main_nxt = push_res;
      end
    end else if (push) begin
      skid_nxt       = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  // skid only ever holds a word behind a full main register
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word without main word");

  // skid fills only when main was stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(main_valid_r && !out_ready))
    else $error("skid filled while main was draining");

  // no word is pushed while the skid is occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("word pushed into full buffer");

endmodule

/* rtl/mavlink_v2_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// mavlink_v2_frame_receiver_top
// MAVLink v2 frame receiver: one link byte in, payload bytes and reports out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received link byte per word (in_valid / in_ready).
//   out_* : result words. Kind 0 carries one payload byte with its index,
//           kind 1 is the frame-end report with ids, length, CRC match and
//           over-length flag. Bytes outside a frame, header bytes and the
//           low checksum byte give no result.
//   cfg_* : register writes (start marker, CRC extra byte, length limit);
//           cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. Each byte is handled
//   in a single pass through the parser logic into the output stage.
// Output: each result is registered in the output stage before it reaches out_*.
// Stall: a result register plus a one-word skid stage; in_ready is low only
//   while the skid holds a word, so one extra result word is absorbed after
//   out_ready drops, and no result is lost.
// Reset: rst_n (synchronous) clears the parser to hunting, seeds the CRC to
//   0xFFFF, restores the register defaults and empties the output stage.
// ----------------------------------------------------------------------------
module mavlink_v2_frame_receiver_top
  import mvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // link bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [7:0]           out_data_byte,
  output logic [7:0]           out_payload_index,
  output logic [7:0]           out_payload_length,
  output logic [7:0]           out_system_id,
  output logic [7:0]           out_component_id,
  output logic [23:0]          out_message_id,
  output logic                 out_crc_match,
  output logic                 out_over_length,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_push;
  logic can_push;
  logic byte_en;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_push;
  assign byte_en   = in_valid && can_push;

  mvr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mvr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .byte_en  (byte_en),
    .rx_byte  (in_rx_byte),
    .res_push (res_push),
    .res      (res)
  );

  mvr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind    = out_res.result_kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_payload_index  = out_res.payload_index;
  assign out_payload_length = out_res.payload_length;
  assign out_system_id      = out_res.system_id;
  assign out_component_id   = out_res.component_id;
  assign out_message_id     = out_res.message_id;
  assign out_crc_match      = out_res.crc_match;
  assign out_over_length    = out_res.over_length;

endmodule

/* dv/mavlink_v2_frame_receiver_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_v2_frame_receiver_checker
// Passive scoreboard for the v2 frame receiver. It follows the config writes
// and link bytes, predicts every result word and compares the words that
// leave the block field by field, in order.
// ----------------------------------------------------------------------------

// Checksum step shared by the checker and the frame builder in the bench top
package mvr_dv_pkg;

  // Reflected CCITT polynomial, one bit at a time
  function automatic logic [15:0] x25_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module mavlink_v2_frame_receiver_checker
  import mvr_pkg::*;
  import mvr_dv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_result_kind,
  input  logic [7:0]           out_data_byte,
  input  logic [7:0]           out_payload_index,
  input  logic [7:0]           out_payload_length,
  input  logic [7:0]           out_system_id,
  input  logic [7:0]           out_component_id,
  input  logic [23:0]          out_message_id,
  input  logic                 out_crc_match,
  input  logic                 out_over_length,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   pending_words,
  output int                   mismatch_count,
  output int                   payload_words,
  output int                   frame_reports,
  output int                   crc_good_reports,
  output int                   over_reports
);

  typedef enum logic [2:0] {SCAN, HDR, BODY, SUM_LO, SUM_HI} parse_phase_e;

  // Shadow of the parser
  parse_phase_e phase_q;
  logic [7:0]   cnt_q;
  logic [7:0]   len_q;
  logic [7:0]   sys_q;
  logic [7:0]   comp_q;
  logic [23:0]  msg_q;
  logic [15:0]  crc_q;
  logic [7:0]   sum_lo_q;

  // Shadow of the registers
  logic [7:0]   marker_q;
  logic [7:0]   extra_q;
  logic [7:0]   max_len_q;

  res_t expected_words[$];
  int   errs;
  int   word_no;
  int   n_payload;
  int   n_report;
  int   n_crc_good;
  int   n_over;

  initial begin
    errs = 0;
    word_no = 0;
    n_payload = 0;
    n_report = 0;
    n_crc_good = 0;
    n_over = 0;
  end

  task automatic note_error(input string msg);
    errs++;
    if (errs <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got)
      note_error($sformatf("word %0d %s: expected 0x%0h, got 0x%0h",
                           word_no, name, want, got));
  endtask

  // Build a result word from the captured header
  function automatic res_t make_word(input logic kind, input logic [7:0] data,
                                     input logic [7:0] idx, input logic match,
                                     input logic over);
    res_t w;
    w.result_kind    = kind;
    w.data_byte      = data;
    w.payload_index  = idx;
    w.payload_length = len_q;
    w.system_id      = sys_q;
    w.component_id   = comp_q;
    w.message_id     = msg_q;
    w.crc_match      = match;
    w.over_length    = over;
    return w;
  endfunction

  // Payload done: fold the extra byte, then expect the checksum
  task automatic close_body();
    crc_q = x25_crc_step(crc_q, extra_q);
    phase_q = SUM_LO;
  endtask

  // Advance the shadow parser by one link byte
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] idx;
    case (phase_q)
      SCAN: begin
        if (b == marker_q) begin
          crc_q = x25_crc_step(CRC_SEED, b);
          cnt_q = 8'd1;
          phase_q = HDR;
        end
      end
      HDR: begin
        crc_q = x25_crc_step(crc_q, b);
        case (cnt_q)
          8'd1: len_q = b;
          8'd5: sys_q = b;
          8'd6: comp_q = b;
          8'd7: msg_q = {16'h0000, b};
          8'd8: msg_q[15:8] = b;
          8'd9: msg_q[23:16] = b;
          default: ;
        endcase
        cnt_q = cnt_q + 8'd1;
        if (cnt_q >= 8'd10) begin
          cnt_q = 8'd0;
          if (len_q == 8'd0) close_body();
          else phase_q = BODY;
        end
      end
      BODY: begin
        idx = cnt_q;
        crc_q = x25_crc_step(crc_q, b);
        expected_words.push_back(make_word(RES_PAYLOAD, b, idx, 1'b0, 1'b0));
        cnt_q = cnt_q + 8'd1;
        if ({1'b0, idx} + 9'd1 >= {1'b0, len_q}) begin
          cnt_q = 8'd0;
          close_body();
        end
      end
      SUM_LO: begin
        sum_lo_q = b;
        phase_q = SUM_HI;
      end
      default: begin
        expected_words.push_back(make_word(RES_FRAME_END, 8'h00, 8'h00,
                                           {b, sum_lo_q} == crc_q, len_q > max_len_q));
        phase_q = SCAN;
        cnt_q = 8'd0;
        crc_q = CRC_SEED;
      end
    endcase
  endtask

  task automatic compare_word(input res_t got);
    res_t want;
    if (expected_words.size() == 0) begin
      note_error($sformatf("word %0d arrived with nothing expected (kind %0d)",
                           word_no, got.result_kind));
    end else begin
      want = expected_words.pop_front();
      check_field("result_kind",    24'(want.result_kind),    24'(got.result_kind));
      check_field("data_byte",      24'(want.data_byte),      24'(got.data_byte));
      check_field("payload_index",  24'(want.payload_index),  24'(got.payload_index));
      check_field("payload_length", 24'(want.payload_length), 24'(got.payload_length));
      check_field("system_id",      24'(want.system_id),      24'(got.system_id));
      check_field("component_id",   24'(want.component_id),   24'(got.component_id));
      check_field("message_id",     want.message_id,          got.message_id);
      check_field("crc_match",      24'(want.crc_match),      24'(got.crc_match));
      check_field("over_length",    24'(want.over_length),    24'(got.over_length));
    end
    if (got.result_kind == RES_FRAME_END) begin
      n_report++;
      if (got.crc_match) n_crc_good++;
      if (got.over_length) n_over++;
    end else begin
      n_payload++;
    end
    word_no++;
  endtask

  // Watch all three channels; results leave before the byte of this edge is parsed
  always @(posedge clk) begin : watch
    res_t got;
    if (!rst_n) begin
      phase_q   = SCAN;
      cnt_q     = 8'd0;
      len_q     = 8'd0;
      sys_q     = 8'd0;
      comp_q    = 8'd0;
      msg_q     = 24'd0;
      crc_q     = CRC_SEED;
      sum_lo_q  = 8'd0;
      marker_q  = START_MARKER_RST;
      extra_q   = CRC_EXTRA_RST;
      max_len_q = MAX_PAYLOAD_RST;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_MARKER: marker_q = cfg_data;
          REG_CRC_EXTRA:    extra_q = cfg_data;
          REG_MAX_PAYLOAD:  max_len_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.result_kind    = out_result_kind;
        got.data_byte      = out_data_byte;
        got.payload_index  = out_payload_index;
        got.payload_length = out_payload_length;
        got.system_id      = out_system_id;
        got.component_id   = out_component_id;
        got.message_id     = out_message_id;
        got.crc_match      = out_crc_match;
        got.over_length    = out_over_length;
        compare_word(got);
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
    end
    pending_words    <= expected_words.size();
    mismatch_count   <= errs;
    payload_words    <= n_payload;
    frame_reports    <= n_report;
    crc_good_reports <= n_crc_good;
    over_reports     <= n_over;
  end

endmodule

/* dv/mavlink_v2_frame_receiver_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_v2_frame_receiver_top_tb
// Drives link bytes, register writes and output back-pressure into the v2
// frame receiver. A short directed sequence is followed by random frames,
// corrupt frames, truncated frames and noise under several register
// settings; the checker instance scores every result word.
// ----------------------------------------------------------------------------
module mavlink_v2_frame_receiver_top_tb;
  import mvr_pkg::*;
  import mvr_dv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_BYTES    = 95;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_result_kind;
  logic [7:0]           out_data_byte;
  logic [7:0]           out_payload_index;
  logic [7:0]           out_payload_length;
  logic [7:0]           out_system_id;
  logic [7:0]           out_component_id;
  logic [23:0]          out_message_id;
  logic                 out_crc_match;
  logic                 out_over_length;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_MARKER;
  logic [7:0]           cfg_data = 8'h00;

  int pending_words;
  int mismatch_count;
  int payload_words;
  int frame_reports;
  int crc_good_reports;
  int over_reports;

  // Settings currently loaded, used to build frames
  logic [7:0] marker_cfg = START_MARKER_RST;
  logic [7:0] extra_cfg  = CRC_EXTRA_RST;
  logic [7:0] frame_q[$];
  bit         steady = 1'b0;
  int         sent_bytes = 0;
  int         idle_cycles = 0;

  mavlink_v2_frame_receiver_top dut (.*);
  mavlink_v2_frame_receiver_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Stop a hung run: count cycles in which no channel moves a word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Output back-pressure: free-running stretches, short flicker, long stalls
  initial begin : sink
    int r;
    @(posedge clk iff rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else if (r < 88) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 75) return 8'($urandom_range(1, 12));
    if (r < 95) return 8'($urandom_range(13, 40));
    return 8'($urandom_range(41, 80));
  endfunction

  // Offer one link byte, with a random gap ahead of it
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Assemble a full frame for the current settings into frame_q
  task automatic build_frame(input logic [7:0] len, input logic [7:0] sys,
                             input logic [7:0] comp, input logic [23:0] msg,
                             input bit bad_sum, input bit marker_in_body);
    logic [7:0]  hdr[10];
    logic [15:0] sum;
    logic [7:0]  pb;
    hdr = '{marker_cfg, len, 8'($urandom), 8'($urandom), 8'($urandom),
            sys, comp, msg[7:0], msg[15:8], msg[23:16]};
    frame_q.delete();
    sum = CRC_SEED;
    for (int i = 0; i < 10; i++) begin
      sum = x25_crc_step(sum, hdr[i]);
      frame_q.push_back(hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      pb = (marker_in_body && i == 0) ? marker_cfg : 8'($urandom);
      sum = x25_crc_step(sum, pb);
      frame_q.push_back(pb);
    end
    sum = x25_crc_step(sum, extra_cfg);
    if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(sum[7:0]);
    frame_q.push_back(sum[15:8]);
  endtask

  task automatic send_prefix(input int n);
    for (int i = 0; i < n && i < frame_q.size(); i++) push_byte(frame_q[i]);
  endtask

  // Let every expected word drain, then give the parser time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] marker, input logic [7:0] extra,
                                input logic [7:0] max_len, input bit hit_unused);
    write_reg(REG_START_MARKER, marker);
    write_reg(REG_CRC_EXTRA, extra);
    write_reg(REG_MAX_PAYLOAD, max_len);
    // a write to the spare index must leave all settings alone
    if (hit_unused) write_reg(REG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    marker_cfg = marker;
    extra_cfg = extra;
  endtask

  // Mostly clean frames; some corrupt, cut short or pure noise
  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int r;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 82) begin
        build_frame(rand_len(), 8'($urandom), 8'($urandom), 24'($urandom),
                    r >= 72, $urandom_range(0, 9) == 0);
        send_prefix(frame_q.size());
      end else if (r < 91) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else begin
        build_frame(rand_len(), 8'($urandom), 8'($urandom), 24'($urandom), 1'b0, 1'b0);
        send_prefix($urandom_range(1, frame_q.size() - 1));
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise at both byte extremes, an empty frame with a good
    // checksum, then a one-byte frame carrying the start marker as data
    // and a broken checksum
    push_byte(8'h00);
    push_byte(8'hFF);
    build_frame(8'd0, 8'hFF, 8'h00, 24'hFFFFFF, 1'b0, 1'b0);
    send_prefix(frame_q.size());
    build_frame(8'd1, 8'h00, 8'hFF, 24'h000000, 1'b1, 1'b1);
    send_prefix(frame_q.size());
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apply_settings(8'h00, 8'hFF, 8'h00, 1'b0);
        1: apply_settings(8'hFF, 8'h00, 8'hFF, 1'b1);
        2: apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(0, 40)), 1'b1);
        default: apply_settings(START_MARKER_RST, 8'($urandom), 8'($urandom), 1'b0);
      endcase
      // parser is hunting here, so the longest payload runs its full index range
      if (ph == 0) begin
        steady = 1'b0;
        build_frame(8'hFF, 8'($urandom), 8'($urandom), 24'($urandom), 1'b0, 1'b0);
        send_prefix(frame_q.size());
      end
      random_traffic(PHASE_BYTES);
      wait_idle();
    end

    $display("Sent %0d link bytes under 5 register settings; seen %0d payload words,",
             sent_bytes, payload_words);
    $display("%0d frame reports (%0d with matching checksum, %0d over-length).",
             frame_reports, crc_good_reports, over_reports);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatch_count, pending_words);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
